FILE: rtl/rxpf_pkg.sv
// ----------------------------------------------------------------------------
// rxpf_pkg
// Shared widths, codes and types for the radius exclusion point filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rxpf_pkg;

	// Field widths
	localparam int COORD_W  = 24;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int SQ_W     = 2 * COORD_W + 1;
	localparam int SUM_W    = SQ_W + 2;
	localparam int RAD_W    = 20;
	localparam int R2_W     = 2 * RAD_W;
	localparam int KEPT_W   = 20;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};

	// Default reference store depth
	localparam int REF_DEPTH_DEF = 1024;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_LOADED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_REFUSED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_KEPT     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd4;

	// One stored reference point
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} ref_pt_t;

endpackage

`default_nettype wire

FILE: rtl/radius_exclusion_point_filter_top.sv
// ----------------------------------------------------------------------------
// radius_exclusion_point_filter_top
// Reference point store with an exact squared-distance exclusion test.
// ----------------------------------------------------------------------------
// Load requests append a 3-D point to a single-port store of REF_DEPTH
// entries; a load into a full store is refused. A query request scans the
// stored points one per cycle through the store's read port and a
// difference / square / sum-and-compare pipeline, and is rejected as soon as
// one point lies strictly inside the exclusion radius. Load and clear go
// straight from idle to the reply state; a query scans first and ends its
// scan early when a point rejects it. A finished result sits in an output
// register, so the next request is taken while the result waits. The user
// must write the radius register only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module radius_exclusion_point_filter_top #(
	parameter int REF_DEPTH = rxpf_pkg::REF_DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration
	input  wire logic                                   cfg_wr_en,
	input  wire logic [rxpf_pkg::RAD_W-1:0]             cfg_wr_data,
	// request channel
	input  wire logic                                   in_valid,
	output      logic                                   in_stall,
	input  wire logic [rxpf_pkg::CMD_W-1:0]             cmd,
	input  wire logic signed [rxpf_pkg::COORD_W-1:0]    point_x,
	input  wire logic signed [rxpf_pkg::COORD_W-1:0]    point_y,
	input  wire logic signed [rxpf_pkg::COORD_W-1:0]    point_z,
	// result channel
	output      logic                                   out_valid,
	input  wire logic                                   out_stall,
	output      logic [rxpf_pkg::STATUS_W-1:0]          status,
	output      logic [rxpf_pkg::KEPT_W-1:0]            kept_number,
	output      logic signed [rxpf_pkg::COORD_W-1:0]    out_x,
	output      logic signed [rxpf_pkg::COORD_W-1:0]    out_y,
	output      logic signed [rxpf_pkg::COORD_W-1:0]    out_z
);

	localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
	localparam int CW = $clog2(REF_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(REF_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_REPLY = 3'b100
	} state_t;

	state_t st_q;

	logic [rxpf_pkg::RAD_W-1:0]   radius_q;
	logic [rxpf_pkg::R2_W-1:0]    r2_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic [rxpf_pkg::KEPT_W-1:0]  kept_q;
	logic                         hit_q;

	// request held during the scan
	logic [rxpf_pkg::COORD_W-1:0] px_q, py_q, pz_q;
	logic [rxpf_pkg::STATUS_W-1:0] status_q;
	logic [rxpf_pkg::KEPT_W-1:0]   number_q;

	// output register
	logic                          out_valid_q;
	logic [rxpf_pkg::STATUS_W-1:0] out_status_q;
	logic [rxpf_pkg::KEPT_W-1:0]   out_number_q;
	logic [rxpf_pkg::COORD_W-1:0]  out_x_q, out_y_q, out_z_q;

	// reference store
	rxpf_pkg::ref_pt_t mem [REF_DEPTH];

	// scan pipeline
	rxpf_pkg::ref_pt_t           rd_s1;
	logic                        v_s1, v_s2, v_s3;
	logic signed [rxpf_pkg::DIFF_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [rxpf_pkg::SQ_W-1:0]   sqx_s3, sqy_s3, sqz_s3;

	logic accept;
	logic do_load;
	logic issue;
	logic scan_live;
	logic scan_done;
	logic out_free;
	logic near;
	logic signed [rxpf_pkg::PROD_W-1:0] prod_x, prod_y, prod_z;
	logic [rxpf_pkg::SUM_W-1:0]  dist_sum;
	logic [rxpf_pkg::KEPT_W-1:0] kept_next;

	// Handshake and control decode
	assign in_stall  = (st_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign do_load   = accept && (cmd == rxpf_pkg::CMD_LOAD) && (count_q != DEPTH_C);
	assign scan_live = (st_q == ST_SCAN) && !hit_q;
	assign issue     = scan_live && (idx_q != count_q);
	assign scan_done = (st_q == ST_SCAN) &&
		(hit_q || ((idx_q == count_q) && !v_s1 && !v_s2 && !v_s3));
	assign out_free  = !out_valid_q || !out_stall;
	assign kept_next = (kept_q == rxpf_pkg::KEPT_MAX) ? kept_q : kept_q + 1'b1;

	// Squares and distance compare
	assign prod_x   = dx_s2 * dx_s2;
	assign prod_y   = dy_s2 * dy_s2;
	assign prod_z   = dz_s2 * dz_s2;
	assign dist_sum = {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};
	assign near     = dist_sum < {{(rxpf_pkg::SUM_W - rxpf_pkg::R2_W){1'b0}}, r2_q};

	// Write loads into the store, read one entry per scan cycle
	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[count_q[AW-1:0]] <= '{x: point_x, y: point_y, z: point_z};
		end
		if (issue) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	// Distance pipeline payload
	always_ff @(posedge clk) begin
		dx_s2  <= $signed({px_q[rxpf_pkg::COORD_W-1], px_q}) -
			$signed({rd_s1.x[rxpf_pkg::COORD_W-1], rd_s1.x});
		dy_s2  <= $signed({py_q[rxpf_pkg::COORD_W-1], py_q}) -
			$signed({rd_s1.y[rxpf_pkg::COORD_W-1], rd_s1.y});
		dz_s2  <= $signed({pz_q[rxpf_pkg::COORD_W-1], pz_q}) -
			$signed({rd_s1.z[rxpf_pkg::COORD_W-1], rd_s1.z});
		sqx_s3 <= prod_x[rxpf_pkg::SQ_W-1:0];
		sqy_s3 <= prod_y[rxpf_pkg::SQ_W-1:0];
		sqz_s3 <= prod_z[rxpf_pkg::SQ_W-1:0];
	end

	// Latch request payload and squared radius
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
			r2_q <= radius_q * radius_q;
			case (cmd)
				rxpf_pkg::CMD_LOAD: begin
					status_q <= (count_q != DEPTH_C) ? rxpf_pkg::STAT_LOADED
						: rxpf_pkg::STAT_REFUSED;
					number_q <= '0;
				end
				rxpf_pkg::CMD_QUERY: begin
					status_q <= rxpf_pkg::STAT_REJECTED;
					number_q <= '0;
				end
				default: begin
					status_q <= rxpf_pkg::STAT_CLEARED;
					number_q <= '0;
				end
			endcase
		end else if (scan_done && !hit_q) begin
			status_q <= rxpf_pkg::STAT_KEPT;
			number_q <= kept_next;
		end
	end

	// Control state: sequencer, counters, pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			radius_q <= '0;
			count_q  <= '0;
			kept_q   <= '0;
			idx_q    <= '0;
			hit_q    <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end

			v_s1 <= issue;
			v_s2 <= v_s1 && scan_live;
			v_s3 <= v_s2 && scan_live;

			if (v_s3 && scan_live && near) begin
				hit_q <= 1'b1;
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end

			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						case (cmd)
							rxpf_pkg::CMD_LOAD: begin
								if (do_load) begin
									count_q <= count_q + 1'b1;
								end
								st_q <= ST_REPLY;
							end
							rxpf_pkg::CMD_QUERY: begin
								st_q <= ST_SCAN;
							end
							default: begin
								count_q <= '0;
								kept_q  <= '0;
								st_q    <= ST_REPLY;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (!hit_q) begin
							kept_q <= kept_next;
						end
						st_q <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == ST_REPLY) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if ((st_q == ST_REPLY) && out_free) begin
			out_status_q <= status_q;
			out_number_q <= number_q;
			out_x_q      <= px_q;
			out_y_q      <= py_q;
			out_z_q      <= pz_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign kept_number = out_number_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;

endmodule

`default_nettype wire

FILE: rtl/rxpf_checker.sv
// ----------------------------------------------------------------------------
// rxpf_checker
// Port-level checks for the radius exclusion point filter.
// ----------------------------------------------------------------------------
`default_nettype none

module rxpf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [rxpf_pkg::STATUS_W-1:0] status,
	input wire logic [rxpf_pkg::KEPT_W-1:0]   kept_number
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// One request at a time: busy right after an accepted request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while still busy");

	// A kept query always carries a nonzero survivor number
	a_kept_numbered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rxpf_pkg::STAT_KEPT) |-> (kept_number != '0))
		else $error("kept query without survivor number");

	// Every other result carries survivor number zero
	a_other_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != rxpf_pkg::STAT_KEPT) |-> (kept_number == '0))
		else $error("survivor number on a non-kept result");

endmodule

bind radius_exclusion_point_filter_top rxpf_checker u_rxpf_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_radius_exclusion_point_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radius_exclusion_point_filter_top
// Self-checking bench for the radius exclusion point filter.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the coordinate extremes, zero and
// full radius, the exact distance boundary, clear and the spare command code.
// A store-filling pass drives the store to capacity and past it. Random
// clusters of loads and nearby queries follow, under changing radius settings
// and random gaps on both channels. Every result is compared field by field
// with the typed row's expected fields or a bit-accurate prediction.
// ----------------------------------------------------------------------------

module tb_radius_exclusion_point_filter_top;

	import rxpf_pkg::*;

	localparam int TB_DEPTH = REF_DEPTH_DEF;
	localparam int DIR_N    = 22;
	localparam int RAND_ITEMS = 400;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;
	localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

	localparam bit ROW_REQ = 1'b0;
	localparam bit ROW_CFG = 1'b1;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic [KEPT_W-1:0]          kept;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
	} filter_res_t;

	typedef struct packed {
		bit                         kind;
		bit                         typed;
		logic [CMD_W-1:0]           cmd;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic [STATUS_W-1:0]        status;
		logic [KEPT_W-1:0]          kept;
		logic [RAD_W-1:0]           radius;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [RAD_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = CMD_LOAD;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEPT_W-1:0] kept_number;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;

	// Predicted filter state
	logic signed [COORD_W-1:0] ref_xs [TB_DEPTH];
	logic signed [COORD_W-1:0] ref_ys [TB_DEPTH];
	logic signed [COORD_W-1:0] ref_zs [TB_DEPTH];
	int pred_count = 0;
	logic [KEPT_W-1:0] pred_kept = '0;
	logic [RAD_W-1:0] pred_radius = '0;

	filter_res_t pending_results [$];
	dir_row_t dir_tab [DIR_N];
	int mismatch_count = 0;
	bit in_calm = 1'b0;

	radius_exclusion_point_filter_top #(
		.REF_DEPTH(TB_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.kept_number(kept_number),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z)
	);

	// Free-running clock
	always #5 clk = ~clk;

	// Predict one request's result and advance the predicted state
	function automatic filter_res_t predict_filter(input logic [CMD_W-1:0] c,
			input logic signed [COORD_W-1:0] px, py, pz);
		filter_res_t r;
		longint lim;
		longint dx, dy, dz;
		bit keep;
		r.status = STAT_CLEARED;
		r.kept = '0;
		r.x = px;
		r.y = py;
		r.z = pz;
		if (c == CMD_LOAD) begin
			if (pred_count < TB_DEPTH) begin
				ref_xs[pred_count] = px;
				ref_ys[pred_count] = py;
				ref_zs[pred_count] = pz;
				pred_count++;
				r.status = STAT_LOADED;
			end else begin
				r.status = STAT_REFUSED;
			end
		end else if (c == CMD_QUERY) begin
			lim = longint'(pred_radius) * longint'(pred_radius);
			keep = 1'b1;
			for (int i = 0; i < pred_count; i++) begin
				dx = longint'(px) - longint'(ref_xs[i]);
				dy = longint'(py) - longint'(ref_ys[i]);
				dz = longint'(pz) - longint'(ref_zs[i]);
				if (dx * dx + dy * dy + dz * dz < lim) begin
					keep = 1'b0;
					break;
				end
			end
			if (keep) begin
				if (pred_kept != KEPT_MAX)
					pred_kept++;
				r.kept = pred_kept;
				r.status = STAT_KEPT;
			end else begin
				r.status = STAT_REJECTED;
			end
		end else begin
			// bit 1 set: clear, spare code included
			pred_count = 0;
			pred_kept = '0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [COORD_W-1:0] any_coord();
		return COORD_W'($urandom());
	endfunction

	function automatic int jitter(input int s);
		return int'($urandom_range(0, 2 * s)) - s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Present one request, hold it through stalls, log its expected result
	task automatic send_request(input logic [CMD_W-1:0] c,
			input logic signed [COORD_W-1:0] px, py, pz,
			input bit want_on, input filter_res_t want);
		int gap;
		filter_res_t pred;
		gap = in_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		pred = predict_filter(c, px, py, pz);
		pending_results.push_back(want_on ? want : pred);
	endtask

	// Drain the block, then write the radius
	task automatic set_radius(input logic [RAD_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pred_radius = value;
	endtask

	// Result side: random stalls, mostly short, some long, some free stretches
	initial begin
		int run;
		int stl;
		int pick;
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				run = $urandom_range(50, 200);
				stl = 0;
			end else begin
				run = $urandom_range(1, 6);
				stl = (pick < 18) ? $urandom_range(20, 120) : $urandom_range(0, 3);
			end
			out_stall <= 1'b0;
			repeat (run) @(posedge clk);
			if (stl > 0) begin
				out_stall <= 1'b1;
				repeat (stl) @(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		filter_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = pending_results.pop_front();
				check_field("status", status, want.status);
				check_field("kept_number", kept_number, want.kept);
				check_field("out_x", $unsigned(out_x), $unsigned(want.x));
				check_field("out_y", $unsigned(out_y), $unsigned(want.y));
				check_field("out_z", $unsigned(out_z), $unsigned(want.z));
			end
		end
	end

	// Stimulus
	initial begin
		filter_res_t want;
		logic [RAD_W-1:0] rad;
		logic signed [COORD_W-1:0] cx, cy, cz;
		int rand_sent;
		int sp;
		int idx;
		int pick;
		int nload;
		int nq;

		dir_tab[0]  = '{ROW_REQ, 1'b1, CMD_QUERY, '0, '0, '0, STAT_KEPT, 20'd1, '0};
		dir_tab[1]  = '{ROW_REQ, 1'b1, CMD_LOAD, CMAX, CMAX, CMAX, STAT_LOADED, '0, '0};
		dir_tab[2]  = '{ROW_REQ, 1'b1, CMD_QUERY, CMAX, CMAX, CMAX, STAT_KEPT, 20'd2, '0};
		dir_tab[3]  = '{ROW_REQ, 1'b1, CMD_LOAD, CMIN, CMIN, CMIN, STAT_LOADED, '0, '0};
		dir_tab[4]  = '{ROW_CFG, 1'b0, CMD_LOAD, '0, '0, '0, STAT_LOADED, '0, RAD_MAX};
		dir_tab[5]  = '{ROW_REQ, 1'b0, CMD_QUERY, '0, '0, '0, STAT_KEPT, '0, '0};
		dir_tab[6]  = '{ROW_REQ, 1'b1, CMD_QUERY, CMAX, CMAX, CMAX - 24'sd7,
			STAT_REJECTED, '0, '0};
		dir_tab[7]  = '{ROW_REQ, 1'b0, CMD_QUERY, CMIN, CMIN, CMAX, STAT_KEPT, '0, '0};
		dir_tab[8]  = '{ROW_REQ, 1'b0, CMD_QUERY, CMAX, CMIN, '0, STAT_KEPT, '0, '0};
		dir_tab[9]  = '{ROW_REQ, 1'b1, CMD_CLEAR, CMAX, '0, CMIN, STAT_CLEARED, '0, '0};
		dir_tab[10] = '{ROW_REQ, 1'b1, CMD_SPARE, CMIN, CMAX, '0, STAT_CLEARED, '0, '0};
		dir_tab[11] = '{ROW_REQ, 1'b1, CMD_QUERY, CMIN, CMAX, CMIN, STAT_KEPT, 20'd1, '0};
		dir_tab[12] = '{ROW_CFG, 1'b0, CMD_LOAD, '0, '0, '0, STAT_LOADED, '0, 20'd1024};
		dir_tab[13] = '{ROW_REQ, 1'b1, CMD_LOAD, '0, '0, '0, STAT_LOADED, '0, '0};
		dir_tab[14] = '{ROW_REQ, 1'b0, CMD_QUERY, 24'sd1024, '0, '0, STAT_KEPT, '0, '0};
		dir_tab[15] = '{ROW_REQ, 1'b0, CMD_QUERY, 24'sd1023, '0, '0, STAT_KEPT, '0, '0};
		dir_tab[16] = '{ROW_REQ, 1'b0, CMD_QUERY, '0, '0, -24'sd1024, STAT_KEPT, '0, '0};
		dir_tab[17] = '{ROW_REQ, 1'b0, CMD_QUERY, 24'sd591, 24'sd591, 24'sd591,
			STAT_KEPT, '0, '0};
		dir_tab[18] = '{ROW_REQ, 1'b0, CMD_QUERY, -24'sd592, 24'sd592, -24'sd592,
			STAT_KEPT, '0, '0};
		dir_tab[19] = '{ROW_CFG, 1'b0, CMD_LOAD, '0, '0, '0, STAT_LOADED, '0, 20'd1};
		dir_tab[20] = '{ROW_REQ, 1'b0, CMD_QUERY, '0, '0, 24'sd1, STAT_KEPT, '0, '0};
		dir_tab[21] = '{ROW_REQ, 1'b0, CMD_QUERY, '0, '0, '0, STAT_KEPT, '0, '0};

		// Hold reset, then release it on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIR_N; i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				set_radius(dir_tab[i].radius);
			end else begin
				want = '{dir_tab[i].status, dir_tab[i].kept,
					dir_tab[i].x, dir_tab[i].y, dir_tab[i].z};
				send_request(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
					dir_tab[i].typed, want);
			end
		end

		// Fill the store, overflow it, then query against the full store
		set_radius(20'd4096);
		send_request(CMD_CLEAR, '0, '0, '0, 1'b0, '0);
		for (int i = 0; i < TB_DEPTH + 2; i++)
			send_request(CMD_LOAD, any_coord(), any_coord(), any_coord(), 1'b0, '0);
		send_request(CMD_QUERY, ref_xs[TB_DEPTH / 2], ref_ys[TB_DEPTH / 2],
			ref_zs[TB_DEPTH / 2] + 24'sd5, 1'b0, '0);
		send_request(CMD_QUERY, any_coord(), any_coord(), any_coord(), 1'b0, '0);
		send_request(CMD_QUERY, ref_xs[TB_DEPTH - 1], ref_ys[TB_DEPTH - 1],
			ref_zs[TB_DEPTH - 1], 1'b0, '0);
		send_request(CMD_SPARE, any_coord(), any_coord(), any_coord(), 1'b0, '0);

		// Random clusters of loads with queries around them
		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			in_calm = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				rad = '0;
			else if (pick == 1)
				rad = RAD_MAX;
			else if (pick < 7)
				rad = RAD_W'($urandom_range(1, 4096));
			else
				rad = RAD_W'($urandom());
			set_radius(rad);
			sp = (rad == 0) ? 256 : int'(rad);

			// Drop the old cluster now and then, and keep the store small
			if (pred_count > 48 || $urandom_range(0, 3) == 0) begin
				send_request($urandom_range(0, 1) ? CMD_CLEAR : CMD_SPARE,
					any_coord(), any_coord(), any_coord(), 1'b0, '0);
				rand_sent++;
			end

			cx = any_coord();
			cy = any_coord();
			cz = any_coord();
			nload = $urandom_range(1, 12);
			for (int k = 0; k < nload; k++) begin
				send_request(CMD_LOAD, cx + COORD_W'(jitter(2 * sp)),
					cy + COORD_W'(jitter(2 * sp)), cz + COORD_W'(jitter(2 * sp)),
					1'b0, '0);
				rand_sent++;
			end

			nq = $urandom_range(2, 10);
			for (int k = 0; k < nq; k++) begin
				pick = $urandom_range(0, 15);
				if (pick < 2) begin
					send_request(CMD_W'($urandom()), any_coord(), any_coord(),
						any_coord(), 1'b0, '0);
				end else if (pick < 5 || pred_count == 0) begin
					send_request(CMD_QUERY, any_coord(), any_coord(), any_coord(),
						1'b0, '0);
				end else begin
					idx = $urandom_range(0, pred_count - 1);
					send_request(CMD_QUERY, ref_xs[idx] + COORD_W'(jitter(sp)),
						ref_ys[idx] + COORD_W'(jitter(sp)),
						ref_zs[idx] + COORD_W'(jitter(sp)), 1'b0, '0);
				end
				rand_sent++;
			end
		end

		// Drain and finish
		in_valid <= 1'b0;
		in_calm = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#30_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rxpf_pkg.sv
rtl/radius_exclusion_point_filter_top.sv
rtl/rxpf_checker.sv
tb/sv/tb_radius_exclusion_point_filter_top.sv
